[hw/rtl/h2r_pkg.sv]
package h2r_pkg;

   // Number of register stages from an accepted request to the response register.
   localparam int unsigned PIPE_DEPTH = 6;

   // Which piece of the hue ramp a channel falls on.
   typedef enum logic [1:0] {
      REGION_RISE,
      REGION_HOLD_Q,
      REGION_FALL,
      REGION_HOLD_P
   } h2r_region_type;

endpackage

[hw/rtl/h2r_channel.sv]
module h2r_channel #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [FRAC_BITS+2:0] hue_shift,
   input  logic        [FRAC_BITS:0]   p_value,
   input  logic        [FRAC_BITS:0]   q_value,
   input  logic        [FRAC_BITS:0]   d_value,
   output logic        [7:0]           channel_byte
);
   import h2r_pkg::*;

   localparam int unsigned VW         = FRAC_BITS + 1;
   localparam int unsigned TW         = FRAC_BITS + 3;
   localparam int unsigned MW         = FRAC_BITS + 2;
   localparam int unsigned PW         = VW + MW;
   localparam int unsigned ONE_I      = 1 << FRAC_BITS;
   localparam int unsigned HALF_I     = ONE_I / 2;
   localparam int unsigned SIXTH_I    = (ONE_I + 3) / 6;
   localparam int unsigned TWO_3RDS_I = (2 * ONE_I + 1) / 3;

   localparam logic signed [TW-1:0] ONE_S   = TW'(ONE_I);
   localparam logic [VW-1:0] ONE_V          = VW'(ONE_I);
   localparam logic [VW-1:0] HALF_V         = VW'(HALF_I);
   localparam logic [VW-1:0] SIXTH_V        = VW'(SIXTH_I);
   localparam logic [VW-1:0] TWO_3RDS_V     = VW'(TWO_3RDS_I);

   logic signed [TW-1:0] wrap_t;
   logic [VW-1:0]        t_in, t_ff;
   h2r_region_type       region3_in, region3_ff, region4_ff;
   logic [MW-1:0]        slope3_in, slope3_ff;
   logic [VW-1:0]        fall_span;
   logic [PW-1:0]        prod4_in, prod4_ff;
   logic [VW-1:0]        p4_ff, q4_ff;
   logic [VW:0]          level5;
   logic [VW-1:0]        level5_in, level5_ff;
   logic [VW+7:0]        scaled6;
   logic [8:0]           byte6;
   logic [7:0]           byte6_in, byte_ff;

   // Stage 2: wrap the shifted hue once into [0, 1].
   always_comb begin
      wrap_t = hue_shift;
      if (wrap_t < 0) begin
         wrap_t = wrap_t + ONE_S;
      end else if (wrap_t > ONE_S) begin
         wrap_t = wrap_t - ONE_S;
      end
      if (wrap_t < 0) begin
         wrap_t = '0;
      end
      t_in = VW'(wrap_t);
   end

   // Stage 3: pick the ramp piece and form six times the distance along the slope.
   always_comb begin
      fall_span = TWO_3RDS_V - t_ff;
      if (t_ff < SIXTH_V) begin
         region3_in = REGION_RISE;
         slope3_in  = (MW'(t_ff) << 2) + (MW'(t_ff) << 1);
      end else if (t_ff < HALF_V) begin
         region3_in = REGION_HOLD_Q;
         slope3_in  = '0;
      end else if (t_ff < TWO_3RDS_V) begin
         region3_in = REGION_FALL;
         slope3_in  = (MW'(fall_span) << 2) + (MW'(fall_span) << 1);
      end else begin
         region3_in = REGION_HOLD_P;
         slope3_in  = '0;
      end
   end

   // Stage 4: slope product; d arrives from the stage 3 register of the top level.
   assign prod4_in = PW'(d_value) * PW'(slope3_ff);

   // Stage 5: channel level, clamped to one.
   always_comb begin
      case (region4_ff) inside
         REGION_RISE, REGION_FALL: begin
            level5 = {1'b0, p4_ff} + {1'b0, prod4_ff[FRAC_BITS +: VW]};
         end
         REGION_HOLD_Q: begin
            level5 = {1'b0, q4_ff};
         end
         default: begin
            level5 = {1'b0, p4_ff};
         end
      endcase
      if (level5 > {1'b0, ONE_V}) begin
         level5_in = ONE_V;
      end else begin
         level5_in = level5[VW-1:0];
      end
   end

   // Stage 6: scale by 255 as a shift and subtract, then saturate to a byte.
   always_comb begin
      scaled6 = {level5_ff, 8'b0} - {8'b0, level5_ff};
      byte6   = scaled6[FRAC_BITS +: 9];
      if (byte6 > 9'd255) begin
         byte6_in = 8'hff;
      end else begin
         byte6_in = byte6[7:0];
      end
   end

   // Payload registers move together with the pipeline advance.
   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff       <= t_in;
         region3_ff <= region3_in;
         slope3_ff  <= slope3_in;
         region4_ff <= region3_ff;
         prod4_ff   <= prod4_in;
         p4_ff      <= p_value;
         q4_ff      <= q_value;
         level5_ff  <= level5_in;
         byte_ff    <= byte6_in;
      end
   end

   assign channel_byte = byte_ff;

endmodule

[hw/rtl/hsl_to_rgb_converter.sv]
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall req_hue, req_saturation, req_lightness
// rsp_      out        rsp_valid/rsp_stall rsp_red, rsp_green, rsp_blue
//
// One pixel enters per clock while req_stall is low; its response leaves the last stage.
// The six register stages are: saturate, q multiply, q/p and ramp piece, slope multiply,
// level select, byte scaling.
// Synchronous reset clears the stage valid bits only.
// A stalled response holds the whole pipeline, so req_stall follows rsp_stall while
// a response waits; empty stages keep their place and nothing is lost or repeated.
module hsl_to_rgb_converter #(
   parameter int unsigned FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_hue,
   input  logic [15:0] req_saturation,
   input  logic [15:0] req_lightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);
   import h2r_pkg::*;

   localparam int unsigned VW      = FRAC_BITS + 1;
   localparam int unsigned TW      = FRAC_BITS + 3;
   localparam int unsigned SW      = FRAC_BITS + 4;
   localparam int unsigned PW      = 2 * VW + 1;
   localparam int unsigned ONE_I   = 1 << FRAC_BITS;
   localparam int unsigned HALF_I  = ONE_I / 2;
   localparam int unsigned THIRD_I = (ONE_I + 1) / 3;

   localparam logic [VW-1:0] ONE_V  = VW'(ONE_I);
   localparam logic [VW-1:0] HALF_V = VW'(HALF_I);
   localparam logic signed [TW-1:0] THIRD_S = TW'(THIRD_I);

   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;

   logic [VW-1:0]         h1_in, s1_in, l1_in;
   logic [VW-1:0]         h1_ff, s1_ff, l1_ff;
   logic [VW:0]           mult2;
   logic [PW-1:0]         prod2_in, prod2_ff;
   logic [VW-1:0]         s2_ff, l2_ff;
   logic                  lhalf2_ff;
   logic signed [SW-1:0]  q3, p3, d3;
   logic [VW-1:0]         q3_in, p3_in, d3_in;
   logic [VW-1:0]         q3_ff, p3_ff, d3_ff;
   logic signed [TW-1:0]  hue_plus, hue_mid, hue_minus;

   function automatic logic [VW-1:0] sat_one(input logic [15:0] raw);
      logic [VW-1:0] clipped;
      if ({16'b0, raw} > 32'(ONE_I)) begin
         clipped = ONE_V;
      end else begin
         clipped = VW'(raw);
      end
      return clipped;
   endfunction

   // The whole pipeline moves unless a response waits on a stall.
   assign advance   = !(valid_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;

   // Valid bits travel alongside the data.
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: saturate the inputs to one.
   assign h1_in = sat_one(req_hue);
   assign s1_in = sat_one(req_saturation);
   assign l1_in = sat_one(req_lightness);

   // Stage 2: one multiplier serves both forms of q.
   assign mult2    = (l1_ff < HALF_V) ? ({1'b0, ONE_V} + {1'b0, s1_ff}) : {1'b0, s1_ff};
   assign prod2_in = PW'(l1_ff) * PW'(mult2);

   // Stage 3: q, p and the spread between them; zero saturation gives gray.
   always_comb begin
      if (lhalf2_ff) begin
         q3 = SW'(prod2_ff[FRAC_BITS +: VW+1]);
      end else begin
         q3 = SW'(l2_ff) + SW'(s2_ff) - SW'(prod2_ff[FRAC_BITS +: VW+1]);
      end
      if (s2_ff == '0) begin
         q3 = SW'(l2_ff);
      end
      p3 = (SW'(l2_ff) <<< 1) - q3;
      if (p3 < 0) begin
         p3 = '0;
      end
      d3 = q3 - p3;
      if (d3 < 0) begin
         d3 = '0;
      end
      q3_in = VW'(q3);
      p3_in = VW'(p3);
      d3_in = VW'(d3);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h1_ff     <= h1_in;
         s1_ff     <= s1_in;
         l1_ff     <= l1_in;
         prod2_ff  <= prod2_in;
         s2_ff     <= s1_ff;
         l2_ff     <= l1_ff;
         lhalf2_ff <= (l1_ff < HALF_V);
         q3_ff     <= q3_in;
         p3_ff     <= p3_in;
         d3_ff     <= d3_in;
      end
   end

   // Hue offsets for the three channels, taken from the stage 1 register.
   assign hue_mid   = $signed({2'b00, h1_ff});
   assign hue_plus  = hue_mid + THIRD_S;
   assign hue_minus = hue_mid - THIRD_S;

   h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
      .clock        (clock),
      .advance      (advance),
      .hue_shift    (hue_plus),
      .p_value      (p3_ff),
      .q_value      (q3_ff),
      .d_value      (d3_ff),
      .channel_byte (rsp_red)
   );

   h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
      .clock        (clock),
      .advance      (advance),
      .hue_shift    (hue_mid),
      .p_value      (p3_ff),
      .q_value      (q3_ff),
      .d_value      (d3_ff),
      .channel_byte (rsp_green)
   );

   h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
      .clock        (clock),
      .advance      (advance),
      .hue_shift    (hue_minus),
      .p_value      (p3_ff),
      .q_value      (q3_ff),
      .d_value      (d3_ff),
      .channel_byte (rsp_blue)
   );

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

endmodule

[hw/rtl/h2r_checker.sv]
module h2r_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [15:0] req_saturation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue
);

   // A stalled response beat holds its color.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("response beat changed while stalled");

   // Requests are held off only by a waiting response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting response");

   // With no stalls, a request beat shows up as a response after passing every stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response beat missing after pipeline latency");

   // Zero saturation gives a gray response.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_saturation == 16'd0) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         |=> rsp_red == rsp_green && rsp_green == rsp_blue)
      else $error("achromatic pixel did not come out gray");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_saturation (req_saturation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);
